// ===== rtl/lsf_pkg.sv =====
// Shared constants and state encoding of the linear sieve factorizer.
package lsf_pkg;

  // Sieve bounds
  localparam int LIMIT       = 65535;
  localparam int PRIME_SLOTS = 8192;
  localparam int TABLE_TOP   = (LIMIT < 65535) ? LIMIT : 65535;
  localparam int SF_DEPTH    = TABLE_TOP + 1;

  // Field and counter widths
  localparam int NUM_W  = 16;
  localparam int SF_AW  = $clog2(SF_DEPTH);
  localparam int SI_W   = $clog2(TABLE_TOP + 2);
  localparam int PL_AW  = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
  localparam int PC_W   = $clog2(PRIME_SLOTS + 1);
  localparam int PROD_W = SI_W + NUM_W;
  localparam int DCNT_W = $clog2(NUM_W);

  // A 16-bit number has at most fifteen prime factors
  localparam int MAX_RESULTS = 15;
  localparam int K_W         = 4;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_SV_RD  = 11'b000_0000_0010,
    S_SV_CHK = 11'b000_0000_0100,
    S_SV_PRD = 11'b000_0000_1000,
    S_SV_MUL = 11'b000_0001_0000,
    S_SV_WR  = 11'b000_0010_0000,
    S_IDLE   = 11'b000_0100_0000,
    S_Q_RD   = 11'b000_1000_0000,
    S_Q_F    = 11'b001_0000_0000,
    S_DIV    = 11'b010_0000_0000,
    S_RES    = 11'b100_0000_0000
  } lsf_state_t;

endpackage

// ===== rtl/lsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/linear_sieve_factorizer_core.sv =====
// Top level of the linear sieve factorizer: sieve sequencer, query sequencer and divider.
//
// After reset the block sweeps its 65536-entry smallest-prime-factor table to
// zero in a clearing pass, then runs a linear (Euler) sieve over
// 2..TABLE_TOP, filling the table and a list of primes; in_stall stays high
// until the sieve is done. A word on the input channel is then one 16-bit
// number. It yields one result word per prime factor, smallest first; the
// final word has out_last set, and every word carries whether the number is
// prime. Numbers 0 and 1 give a single word with factor 0; numbers above
// LIMIT give a single word with factor 0 and out_out_of_range set. One number
// is worked on at a time and in_stall is high until its final word has been
// loaded into the output register. Each factor goes through the table read
// through its registered port, then the one-bit-per-cycle restoring divider
// that strips the factor from the remainder, then the hand-off of the word to
// the output register. Output stall holds up the hand-off only while the
// output register still holds an untaken word.
module linear_sieve_factorizer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lsf_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lsf_pkg::NUM_W-1:0] out_factor,
  output logic                      out_last,
  output logic                      out_is_prime_flag,
  output logic                      out_out_of_range
);

  import lsf_pkg::*;

  lsf_state_t state_r, state_nxt;

  // Sieve control
  logic [SF_AW-1:0]  clr_r, clr_nxt;
  logic [SI_W-1:0]   i_r, i_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [PC_W-1:0]   j_r, j_nxt;
  logic [NUM_W-1:0]  own_r, own_nxt;
  logic [NUM_W-1:0]  p_r, p_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // Query control and divider
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [NUM_W-1:0]  fac_r, fac_nxt;
  logic              pr_r, pr_nxt;
  logic              oor_r, oor_nxt;
  logic [NUM_W-1:0]  div_prem_r, div_prem_nxt;
  logic [NUM_W-1:0]  div_q_r, div_q_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [NUM_W:0]    div_shift;
  logic [NUM_W:0]    div_trial;
  logic [NUM_W-1:0]  f_sel;
  logic              res_last;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]  out_factor_r, out_factor_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_prime_r, out_prime_nxt;
  logic              out_oor_r, out_oor_nxt;
  logic              out_free;

  // Memory ports
  logic              sf_we;
  logic [SF_AW-1:0]  sf_waddr;
  logic [NUM_W-1:0]  sf_wdata;
  logic [SF_AW-1:0]  sf_raddr;
  logic [NUM_W-1:0]  sf_rdata;
  logic              pl_we;
  logic [PL_AW-1:0]  pl_waddr;
  logic [NUM_W-1:0]  pl_wdata;
  logic [PL_AW-1:0]  pl_raddr;
  logic [NUM_W-1:0]  pl_rdata;

  logic              sieve_done;

  lsf_ram #(.WIDTH(NUM_W), .DEPTH(SF_DEPTH)) u_sf_ram (
    .clk   (clk),
    .we    (sf_we),
    .waddr (sf_waddr),
    .wdata (sf_wdata),
    .raddr (sf_raddr),
    .rdata (sf_rdata)
  );

  lsf_ram #(.WIDTH(NUM_W), .DEPTH(PRIME_SLOTS)) u_pl_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  assign sieve_done = (i_r > SI_W'(TABLE_TOP));
  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;

  // Restoring divider step: one quotient bit per cycle
  assign div_shift = {div_prem_r, div_q_r[NUM_W-1]};
  assign div_trial = div_shift - {1'b0, fac_r};

  // A table entry below two stands for the remainder itself
  assign f_sel = (sf_rdata < NUM_W'(2)) ? rem_r : sf_rdata;

  // Final word once the remainder is used up or the result budget is spent
  assign res_last = (div_q_r <= NUM_W'(1)) || (k_r == K_W'(MAX_RESULTS - 1));

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    i_nxt          = i_r;
    pc_nxt         = pc_r;
    j_nxt          = j_r;
    own_nxt        = own_r;
    p_nxt          = p_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    k_nxt          = k_r;
    fac_nxt        = fac_r;
    pr_nxt         = pr_r;
    oor_nxt        = oor_r;
    div_prem_nxt   = div_prem_r;
    div_q_nxt      = div_q_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    out_prime_nxt  = out_prime_r;
    out_oor_nxt    = out_oor_r;

    sf_we    = 1'b0;
    sf_waddr = clr_r;
    sf_wdata = '0;
    sf_raddr = i_r[SF_AW-1:0];
    pl_we    = 1'b0;
    pl_waddr = pc_r[PL_AW-1:0];
    pl_wdata = i_r[NUM_W-1:0];
    pl_raddr = j_r[PL_AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        sf_we    = 1'b1;
        sf_waddr = clr_r;
        sf_wdata = '0;
        clr_nxt  = clr_r + SF_AW'(1);
        if (clr_r == SF_AW'(TABLE_TOP)) begin
          state_nxt = S_SV_RD;
        end
      end

      S_SV_RD: begin
        sf_raddr = i_r[SF_AW-1:0];
        if (sieve_done) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SV_CHK;
        end
      end

      S_SV_CHK: begin
        j_nxt = '0;
        if (sf_rdata == '0) begin
          // Unmarked: i is prime; store it while the list has room
          sf_we    = 1'b1;
          sf_waddr = i_r[SF_AW-1:0];
          sf_wdata = i_r[NUM_W-1:0];
          own_nxt  = i_r[NUM_W-1:0];
          if (pc_r < PC_W'(PRIME_SLOTS)) begin
            pl_we    = 1'b1;
            pl_waddr = pc_r[PL_AW-1:0];
            pl_wdata = i_r[NUM_W-1:0];
            pc_nxt   = pc_r + PC_W'(1);
          end
        end else begin
          own_nxt = sf_rdata;
        end
        state_nxt = S_SV_PRD;
      end

      S_SV_PRD: begin
        pl_raddr = j_r[PL_AW-1:0];
        if (j_r < pc_r) begin
          state_nxt = S_SV_MUL;
        end else begin
          i_nxt     = i_r + SI_W'(1);
          state_nxt = S_SV_RD;
        end
      end

      S_SV_MUL: begin
        p_nxt     = pl_rdata;
        prod_nxt  = PROD_W'(i_r) * PROD_W'(pl_rdata);
        state_nxt = S_SV_WR;
      end

      S_SV_WR: begin
        if ((p_r > own_r) || (prod_r > PROD_W'(TABLE_TOP))) begin
          i_nxt     = i_r + SI_W'(1);
          state_nxt = S_SV_RD;
        end else begin
          sf_we     = 1'b1;
          sf_waddr  = prod_r[SF_AW-1:0];
          sf_wdata  = p_r;
          j_nxt     = j_r + PC_W'(1);
          state_nxt = S_SV_PRD;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          k_nxt   = '0;
          fac_nxt = '0;
          pr_nxt  = 1'b0;
          oor_nxt = 1'b0;
          if (32'(in_number) > 32'(LIMIT)) begin
            oor_nxt   = 1'b1;
            div_q_nxt = '0;
            state_nxt = S_RES;
          end else if (in_number < NUM_W'(2)) begin
            div_q_nxt = '0;
            state_nxt = S_RES;
          end else begin
            rem_nxt   = in_number;
            state_nxt = S_Q_RD;
          end
        end
      end

      S_Q_RD: begin
        sf_raddr  = rem_r[SF_AW-1:0];
        state_nxt = S_Q_F;
      end

      S_Q_F: begin
        // First lookup is of the number itself: prime when it is its own factor
        if (k_r == '0) begin
          pr_nxt = (sf_rdata == rem_r);
        end
        fac_nxt      = f_sel;
        div_prem_nxt = '0;
        div_q_nxt    = rem_r;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end

      S_DIV: begin
        if (!div_trial[NUM_W]) begin
          div_prem_nxt = div_trial[NUM_W-1:0];
          div_q_nxt    = {div_q_r[NUM_W-2:0], 1'b1};
        end else begin
          div_prem_nxt = div_shift[NUM_W-1:0];
          div_q_nxt    = {div_q_r[NUM_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DCNT_W'(1);
        if (div_cnt_r == DCNT_W'(NUM_W - 1)) begin
          state_nxt = S_RES;
        end
      end

      S_RES: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = fac_r;
          out_last_nxt   = res_last;
          out_prime_nxt  = pr_r;
          out_oor_nxt    = oor_r;
          if (res_last) begin
            rem_nxt   = div_q_r;
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = div_q_r;
            k_nxt     = k_r + K_W'(1);
            state_nxt = S_Q_RD;
          end
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      i_r         <= SI_W'(2);
      pc_r        <= '0;
      j_r         <= '0;
      rem_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      i_r         <= i_nxt;
      pc_r        <= pc_nxt;
      j_r         <= j_nxt;
      rem_r       <= rem_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers: no reset
  always_ff @(posedge clk) begin
    own_r        <= own_nxt;
    p_r          <= p_nxt;
    prod_r       <= prod_nxt;
    fac_r        <= fac_nxt;
    pr_r         <= pr_nxt;
    oor_r        <= oor_nxt;
    div_prem_r   <= div_prem_nxt;
    div_q_r      <= div_q_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
    out_prime_r  <= out_prime_nxt;
    out_oor_r    <= out_oor_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_factor        = out_factor_r;
  assign out_last          = out_last_r;
  assign out_is_prime_flag = out_prime_r;
  assign out_out_of_range  = out_oor_r;

`ifndef SYNTHESIS
  a_ready_after_sieve : assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> sieve_done)
    else $error("input taken before the sieve finished");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted word did not make the block busy");

  a_div_factor : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (fac_r >= NUM_W'(2)))
    else $error("divider running with a factor below two");

  a_small_factor_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_factor < NUM_W'(2))) |-> out_last)
    else $error("zero factor word not marked final");

  a_oor_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_last && !out_is_prime_flag))
    else $error("out-of-range word malformed");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for linear_sieve_factorizer_core: directed number table, then random words.
`timescale 1ns / 100ps

module tb_top;
  import lsf_pkg::*;

  // Run control. The clearing pass and the sieve both run before the first
  // number is taken, so the quiet-cycle watchdog must sit well above their
  // combined length.
  localparam int WATCHDOG_LIMIT = 3_000_000;
  // Longer than the worst factorization (15 factors).
  localparam int TAIL_CYCLES    = 300;
  localparam int LONG_HOLD      = 4000;
  localparam int HOLD_AFTER     = 40;
  localparam int RANDOM_ITEMS   = 360;
  localparam int MAX_REPORTS    = 10;

  localparam logic KNOWN   = 1'b1;
  localparam logic PREDICT = 1'b0;

  // One result word as seen on the output channel
  typedef struct packed {
    logic [NUM_W-1:0] factor;
    logic             last;
    logic             prime;
    logic             oor;
  } factor_word_t;

  // One row of the directed table. Rows marked KNOWN carry their answer:
  // kcount words of kfactor, the final one marked last. Others go through
  // the predictor.
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             known;
    logic [NUM_W-1:0] kfactor;
    logic [3:0]       kcount;
    logic             kprime;
  } number_row_t;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // Extremes, the below-two special case (twice more, near the end),
  // primes at both ends of the range, the fifteen-factor maximum, long runs
  // of one factor, many distinct factors and alternating bit patterns.
  // Numbers above LIMIT cannot be formed on a 16-bit port with LIMIT = 65535,
  // so the out-of-range case is only covered by the predictor.
  localparam int DIRECTED_ROWS = 21;
  localparam number_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{16'd0,     KNOWN,   16'd0,     4'd1,  1'b0},
    '{16'd1,     KNOWN,   16'd0,     4'd1,  1'b0},
    '{16'd2,     KNOWN,   16'd2,     4'd1,  1'b1},
    '{16'd3,     KNOWN,   16'd3,     4'd1,  1'b1},
    '{16'd4,     KNOWN,   16'd2,     4'd2,  1'b0},
    '{16'd65535, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd65534, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd65521, KNOWN,   16'd65521, 4'd1,  1'b1},
    '{16'd32768, KNOWN,   16'd2,     4'd15, 1'b0},
    '{16'd49152, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd59049, KNOWN,   16'd3,     4'd10, 1'b0},
    '{16'd30030, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd65025, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd251,   KNOWN,   16'd251,   4'd1,  1'b1},
    '{16'd257,   KNOWN,   16'd257,   4'd1,  1'b1},
    '{16'd4096,  KNOWN,   16'd2,     4'd12, 1'b0},
    '{16'd1,     KNOWN,   16'd0,     4'd1,  1'b0},
    '{16'd0,     KNOWN,   16'd0,     4'd1,  1'b0},
    '{16'd43690, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd21845, PREDICT, 16'd0,     4'd0,  1'b0},
    '{16'd9,     KNOWN,   16'd3,     4'd2,  1'b0}
  };

  // Clock, reset and block inputs, all known from time zero
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [NUM_W-1:0] in_number = '0;
  logic             out_stall = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic [NUM_W-1:0] out_factor;
  logic             out_last;
  logic             out_is_prime_flag;
  logic             out_out_of_range;

  // Bench copy of the smallest-factor table and the prime list
  bit [NUM_W-1:0] least_factor [0:TABLE_TOP];
  bit [NUM_W-1:0] prime_seq [0:PRIME_SLOTS-1];
  int unsigned    primes_found;

  // Words still owed by the block, oldest first
  factor_word_t   awaited_words [$];
  int unsigned    error_count  = 0;
  int unsigned    quiet_cycles = 0;

  always #6 clk = ~clk;

  linear_sieve_factorizer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_factor        (out_factor),
    .out_last          (out_last),
    .out_is_prime_flag (out_is_prime_flag),
    .out_out_of_range  (out_out_of_range)
  );

  // Fill the bench table with a linear sieve. Every composite is struck
  // exactly once, by its smallest prime. Once the list is full, later
  // primes still mark themselves but never strike, so composites whose
  // least prime is unlisted stay empty: the same saturation as the block.
  task automatic run_euler_sieve;
    int unsigned i, j, p, m, own;
    primes_found = 0;
    for (i = 2; i <= TABLE_TOP; i++) begin
      if (least_factor[i] == 0) begin
        least_factor[i] = NUM_W'(i);
        if (primes_found < PRIME_SLOTS) begin
          prime_seq[primes_found] = NUM_W'(i);
          primes_found++;
        end
      end
      own = least_factor[i];
      for (j = 0; j < primes_found; j++) begin
        p = prime_seq[j];
        m = i * p;
        if (p > own || m > TABLE_TOP) break;
        least_factor[m] = NUM_W'(p);
      end
    end
  endtask

  // Queue the words the block owes for one accepted number: peel the
  // smallest factor off the remainder until it reaches one or the result budget is spent.
  task automatic predict_factors(input logic [NUM_W-1:0] n);
    int unsigned  rem, f, k;
    logic         prime;
    factor_word_t w;
    w = '0;
    if (int'(n) > LIMIT) begin
      w.last = 1'b1;
      w.oor  = 1'b1;
      awaited_words = {awaited_words, w};
    end else if (n < 2) begin
      w.last = 1'b1;
      awaited_words = {awaited_words, w};
    end else begin
      prime = (least_factor[n] == n);
      rem   = n;
      k     = 0;
      while (rem > 1 && k < MAX_RESULTS) begin
        f = least_factor[rem];
        // an empty table entry means the remainder is taken whole
        if (f < 2) f = rem;
        rem = rem / f;
        k++;
        w.factor = NUM_W'(f);
        w.last   = (rem <= 1) || (k == MAX_RESULTS);
        w.prime  = prime;
        w.oor    = 1'b0;
        awaited_words = {awaited_words, w};
      end
    end
  endtask

  // Queue the hand-written answer of a directed row
  task automatic push_known(input number_row_t row);
    int unsigned  k;
    factor_word_t w;
    for (k = 1; k <= row.kcount; k++) begin
      w.factor = row.kfactor;
      w.last   = (k == row.kcount);
      w.prime  = row.kprime;
      w.oor    = 1'b0;
      awaited_words = {awaited_words, w};
    end
  endtask

  // Present one number and hold it until the block takes it. Returns in the
  // time step of the accepting edge with valid still high, so a following
  // word in the same burst goes out without a bubble.
  task automatic offer_number(input logic [NUM_W-1:0] n);
    in_valid  <= 1'b1;
    in_number <= n;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every owed word. Always advances at least one
  // edge so valid is never lowered and raised in the same step.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Random numbers weighted towards the interesting parts of the range:
  // plain uniform words, tiny values (below-two included), known primes,
  // smooth numbers with many small factors, powers of two (some tripled), the top of the
  // range and multiples of a small prime.
  function automatic logic [NUM_W-1:0] draw_number();
    int unsigned v, p, sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4:          v = $urandom_range(0, 63);
      5:          v = prime_seq[$urandom_range(0, primes_found - 1)];
      6: begin
        v = 1;
        repeat ($urandom_range(1, 15)) begin
          p = prime_seq[$urandom_range(0, 3)];
          if (v * p <= TABLE_TOP) v = v * p;
        end
      end
      7: begin
        v = 32'd1 << $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 1 && v * 3 <= TABLE_TOP) v = v * 3;
      end
      8:       v = $urandom_range(65000, 65535);
      default: begin
        p = prime_seq[$urandom_range(0, 53)];
        v = p * $urandom_range(1, TABLE_TOP / p);
      end
    endcase
    return NUM_W'(v);
  endfunction

  // Sender: reset, directed table, then random numbers in bursts with gaps.
  // Pause once in the middle until the block has emptied.
  initial begin
    int unsigned idx, burst, sent;
    run_euler_sieve();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The block stalls its input through the clearing pass and the sieve;
    // the first offer simply waits that out.
    for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
      offer_number(DIRECTED_TABLE[idx].number);
      if (DIRECTED_TABLE[idx].known)
        push_known(DIRECTED_TABLE[idx]);
      else
        predict_factors(DIRECTED_TABLE[idx].number);
      idle_gap($urandom_range(0, 1) * $urandom_range(1, 5));
    end
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        offer_number(draw_number());
        predict_factors(in_number);
        burst--;
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_results();
      end
      // roughly a quarter of bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 60));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS linear_sieve_factorizer_core");
    else
      $display("FAIL linear_sieve_factorizer_core");
    $finish;
  end

  // Receiver: stall on stretches of random mode. Once, after a few dozen
  // words, hold off for a long stretch so the output register fills and
  // the block backs up onto its input while the sender keeps offering.
  initial begin
    int unsigned len, k, taken;
    rx_mode_t    mode;
    bit          held;
    taken = 0;
    held  = 1'b0;
    wait (rst_n);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(16, 200);
      for (k = 0; k < len; k++) begin
        @(posedge clk);
        if (out_valid && !out_stall) taken++;
        if (!held && taken >= HOLD_AFTER) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (mode)
            RX_FLOW:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  // Checker: compare each taken word with the oldest owed one
  always @(posedge clk) begin
    factor_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: word with nothing owed: factor %0d last %b prime %b oor %b",
                   $realtime, out_factor, out_last, out_is_prime_flag, out_out_of_range);
        error_count++;
      end else begin
        want = awaited_words.pop_front();
        if (out_factor !== want.factor || out_last !== want.last ||
            out_is_prime_flag !== want.prime || out_out_of_range !== want.oor) begin
          if (error_count < MAX_REPORTS) begin
            $write("%0t: mismatch: expected factor %0d last %b prime %b oor %b,",
                   $realtime, want.factor, want.last, want.prime, want.oor);
            $display(" got factor %0d last %b prime %b oor %b",
                     out_factor, out_last, out_is_prime_flag, out_out_of_range);
          end
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL linear_sieve_factorizer_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
